[hdl/rwl_pkg.sv]
// Package for the reader-writer lock manager: operation and status codes,
// the classified command type and shared constants. No dependencies.
`timescale 1ns / 1ps

package rwl_pkg;

    localparam int DEF_QUEUE_DEPTH  = 16;
    localparam int DEF_TASK_ID_BITS = 8;
    localparam int REQ_FIFO_DEPTH   = 2;
    localparam int OP_BITS          = 3;
    localparam int STATUS_BITS      = 4;
    localparam int RC_BITS          = 8;

    localparam logic [RC_BITS-1:0] COUNT_MAX = '1;

    localparam logic [OP_BITS-1:0] OP_RLOCK     = 3'd0;
    localparam logic [OP_BITS-1:0] OP_TRY_RLOCK = 3'd1;
    localparam logic [OP_BITS-1:0] OP_WLOCK     = 3'd2;
    localparam logic [OP_BITS-1:0] OP_TRY_WLOCK = 3'd3;
    localparam logic [OP_BITS-1:0] OP_RUNLOCK   = 3'd4;
    localparam logic [OP_BITS-1:0] OP_WUNLOCK   = 3'd5;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_GRANTED   = 4'd0,
        ST_REFUSED   = 4'd1,
        ST_QUEUED    = 4'd2,
        ST_RELEASED  = 4'd3,
        ST_WOKE      = 4'd4,
        ST_NOTLOCKED = 4'd5,
        ST_READERS   = 4'd6,
        ST_NOREADERS = 4'd7,
        ST_QFULL     = 4'd8,
        ST_COUNTFULL = 4'd9
    } t_status;

    typedef enum logic [2:0] {
        K_RLOCK,
        K_WLOCK,
        K_RUNLOCK,
        K_WUNLOCK,
        K_BAD
    } t_op_kind;

    typedef struct packed {
        t_op_kind kind;
        logic     try_op;
    } t_cmd;

endpackage

[hdl/rwl_front.sv]
// Front end: classifies the raw operation code of a request into a command.
// Depends on rwl_pkg.
`timescale 1ns / 1ps

module rwl_front
    import rwl_pkg::*;
(
    input  logic [OP_BITS-1:0] i_operation,
    output t_cmd               o_cmd
);

    always_comb begin
        o_cmd.try_op = 1'b0;
        unique case (i_operation) inside
            OP_RLOCK, OP_TRY_RLOCK: begin
                o_cmd.kind   = K_RLOCK;
                o_cmd.try_op = (i_operation == OP_TRY_RLOCK);
            end
            OP_WLOCK, OP_TRY_WLOCK: begin
                o_cmd.kind   = K_WLOCK;
                o_cmd.try_op = (i_operation == OP_TRY_WLOCK);
            end
            OP_RUNLOCK: o_cmd.kind = K_RUNLOCK;
            OP_WUNLOCK: o_cmd.kind = K_WUNLOCK;
            default:    o_cmd.kind = K_BAD;
        endcase
    end

endmodule

[hdl/rwl_fifo.sv]
// Short request queue between the front end and the back end.
// Depends on rwl_pkg for the default depth REQ_FIFO_DEPTH; generic width.
`timescale 1ns / 1ps

module rwl_fifo
    import rwl_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = REQ_FIFO_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_cnt <= r_cnt + CW'(do_push) - CW'(do_pop);
        end
    end

endmodule

[hdl/rwl_back.sv]
// Back end: lock state, reader and writer wait queues and the result register.
// Executes one command at a time; a write-release walks the reader queue.
// Depends on rwl_pkg.
`timescale 1ns / 1ps

module rwl_back
    import rwl_pkg::*;
#(
    parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
    parameter int TASK_ID_BITS = DEF_TASK_ID_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cmd_valid,
    input  t_cmd                    i_cmd,
    input  logic [TASK_ID_BITS-1:0] i_cmd_task,
    output logic                    o_cmd_pop,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output t_status                 o_status,
    output logic [TASK_ID_BITS-1:0] o_task_res,
    output logic                    o_as_writer,
    output logic [RC_BITS-1:0]      o_reader_count,
    output logic                    o_last
);

    localparam int QW  = $clog2(QUEUE_DEPTH);
    localparam int QW1 = QW + 1;
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WAKE
    } t_state;

    t_state                  r_state, n_state;
    t_cmd                    r_cmd, n_cmd;
    logic [TASK_ID_BITS-1:0] r_req_task, n_req_task;
    logic                    r_writer_held, n_writer_held;
    logic [RC_BITS-1:0]      r_readers, n_readers;
    logic [QW-1:0]           r_rq_head, n_rq_head;
    logic [QW-1:0]           r_wq_head, n_wq_head;
    logic [CW-1:0]           r_rq_cnt, n_rq_cnt;
    logic [CW-1:0]           r_wq_cnt, n_wq_cnt;
    logic                    r_out_valid, n_out_valid;
    t_status                 r_status, n_status;
    logic [TASK_ID_BITS-1:0] r_task, n_task;
    logic                    r_wr, n_wr;
    logic                    r_last, n_last;

    logic [TASK_ID_BITS-1:0] rq_mem [QUEUE_DEPTH];
    logic [TASK_ID_BITS-1:0] wq_mem [QUEUE_DEPTH];
    logic [TASK_ID_BITS-1:0] r_rq_rdata;
    logic [TASK_ID_BITS-1:0] r_wq_rdata;

    logic          out_free;
    logic          rq_push, rq_pop, wq_push, wq_pop;
    logic          rq_full, wq_full;
    logic [QW1-1:0] rq_sum, wq_sum;
    logic [QW-1:0] rq_tail, wq_tail;
    logic [QW-1:0] rq_head_inc, wq_head_inc;

    assign out_free    = !r_out_valid || i_out_ready;
    assign rq_full     = (r_rq_cnt == CW'(QUEUE_DEPTH));
    assign wq_full     = (r_wq_cnt == CW'(QUEUE_DEPTH));
    assign rq_sum      = {1'b0, r_rq_head} + QW1'(r_rq_cnt);
    assign wq_sum      = {1'b0, r_wq_head} + QW1'(r_wq_cnt);
    assign rq_tail     = (rq_sum >= QW1'(QUEUE_DEPTH)) ? QW'(rq_sum - QW1'(QUEUE_DEPTH))
                                                       : QW'(rq_sum);
    assign wq_tail     = (wq_sum >= QW1'(QUEUE_DEPTH)) ? QW'(wq_sum - QW1'(QUEUE_DEPTH))
                                                       : QW'(wq_sum);
    assign rq_head_inc = (r_rq_head == QW'(QUEUE_DEPTH - 1)) ? '0 : r_rq_head + 1'b1;
    assign wq_head_inc = (r_wq_head == QW'(QUEUE_DEPTH - 1)) ? '0 : r_wq_head + 1'b1;

    assign o_cmd_pop      = (r_state == S_IDLE) && i_cmd_valid;
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_task_res     = r_task;
    assign o_as_writer    = r_wr;
    assign o_reader_count = r_readers;
    assign o_last         = r_last;

    always_comb begin
        n_state       = r_state;
        n_cmd         = r_cmd;
        n_req_task    = r_req_task;
        n_writer_held = r_writer_held;
        n_readers     = r_readers;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_status      = r_status;
        n_task        = r_task;
        n_wr          = r_wr;
        n_last        = r_last;
        rq_push       = 1'b0;
        rq_pop        = 1'b0;
        wq_push       = 1'b0;
        wq_pop        = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_cmd      = i_cmd;
                    n_req_task = i_cmd_task;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_task      = r_req_task;
                    n_wr        = 1'b0;
                    n_last      = 1'b1;
                    n_status    = ST_REFUSED;
                    n_state     = S_IDLE;
                    case (r_cmd.kind)
                        K_RLOCK: begin
                            if (!r_writer_held && r_wq_cnt == '0) begin
                                if (r_readers == COUNT_MAX) begin
                                    n_status = ST_COUNTFULL;
                                end else begin
                                    n_readers = r_readers + 1'b1;
                                    n_status  = ST_GRANTED;
                                end
                            end else if (r_cmd.try_op) begin
                                n_status = ST_REFUSED;
                            end else if (rq_full) begin
                                n_status = ST_QFULL;
                            end else begin
                                rq_push  = 1'b1;
                                n_status = ST_QUEUED;
                            end
                        end
                        K_WLOCK: begin
                            if (!r_writer_held && r_readers == '0) begin
                                n_writer_held = 1'b1;
                                n_status      = ST_GRANTED;
                                n_wr          = 1'b1;
                            end else if (r_cmd.try_op) begin
                                n_status = ST_REFUSED;
                            end else if (wq_full) begin
                                n_status = ST_QFULL;
                            end else begin
                                wq_push  = 1'b1;
                                n_status = ST_QUEUED;
                            end
                        end
                        K_RUNLOCK: begin
                            if (r_readers == '0) begin
                                n_status = ST_NOREADERS;
                            end else begin
                                n_readers = r_readers - 1'b1;
                                if (r_readers == RC_BITS'(1) && r_wq_cnt != '0) begin
                                    wq_pop        = 1'b1;
                                    n_writer_held = 1'b1;
                                    n_status      = ST_WOKE;
                                    n_task        = r_wq_rdata;
                                    n_wr          = 1'b1;
                                end else begin
                                    n_status = ST_RELEASED;
                                end
                            end
                        end
                        K_WUNLOCK: begin
                            if (!r_writer_held) begin
                                n_status = ST_NOTLOCKED;
                            end else if (r_readers != '0) begin
                                n_status = ST_READERS;
                            end else begin
                                n_writer_held = 1'b0;
                                if (r_rq_cnt != '0) begin
                                    rq_pop    = 1'b1;
                                    n_readers = r_readers + 1'b1;
                                    n_status  = ST_WOKE;
                                    n_task    = r_rq_rdata;
                                    n_last    = (r_rq_cnt == CW'(1));
                                    if (r_rq_cnt != CW'(1)) begin
                                        n_state = S_WAKE;
                                    end
                                end else if (r_wq_cnt != '0) begin
                                    wq_pop        = 1'b1;
                                    n_writer_held = 1'b1;
                                    n_status      = ST_WOKE;
                                    n_task        = r_wq_rdata;
                                    n_wr          = 1'b1;
                                end else begin
                                    n_status = ST_RELEASED;
                                end
                            end
                        end
                        default: n_status = ST_REFUSED;
                    endcase
                end
            end
            S_WAKE: begin
                if (out_free) begin
                    rq_pop      = 1'b1;
                    n_readers   = r_readers + 1'b1;
                    n_out_valid = 1'b1;
                    n_status    = ST_WOKE;
                    n_task      = r_rq_rdata;
                    n_wr        = 1'b0;
                    n_last      = (r_rq_cnt == CW'(1));
                    if (r_rq_cnt == CW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        n_rq_head = rq_pop ? rq_head_inc : r_rq_head;
        n_wq_head = wq_pop ? wq_head_inc : r_wq_head;
        n_rq_cnt  = r_rq_cnt + CW'(rq_push) - CW'(rq_pop);
        n_wq_cnt  = r_wq_cnt + CW'(wq_push) - CW'(wq_pop);
    end

    always_ff @(posedge i_clk) begin
        if (rq_push) begin
            rq_mem[rq_tail] <= r_req_task;
        end
        r_rq_rdata <= rq_mem[n_rq_head];
    end

    always_ff @(posedge i_clk) begin
        if (wq_push) begin
            wq_mem[wq_tail] <= r_req_task;
        end
        r_wq_rdata <= wq_mem[n_wq_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_writer_held <= 1'b0;
            r_readers     <= '0;
            r_rq_head     <= '0;
            r_wq_head     <= '0;
            r_rq_cnt      <= '0;
            r_wq_cnt      <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_writer_held <= n_writer_held;
            r_readers     <= n_readers;
            r_rq_head     <= n_rq_head;
            r_wq_head     <= n_wq_head;
            r_rq_cnt      <= n_rq_cnt;
            r_wq_cnt      <= n_wq_cnt;
            r_out_valid   <= n_out_valid;
        end
        r_cmd      <= n_cmd;
        r_req_task <= n_req_task;
        r_status   <= n_status;
        r_task     <= n_task;
        r_wr       <= n_wr;
        r_last     <= n_last;
    end

    a_excl_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_writer_held && r_readers != '0))
        else $error("writer and readers hold the lock together");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rq_cnt <= CW'(QUEUE_DEPTH) && r_wq_cnt <= CW'(QUEUE_DEPTH))
        else $error("wait queue count beyond depth");

    a_wait_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rq_cnt != '0 |-> (r_writer_held || r_wq_cnt != '0 || r_readers != '0))
        else $error("readers wait with no reason");

    a_wake_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WAKE |-> r_rq_cnt != '0)
        else $error("wake walk on empty reader queue");

endmodule

[hdl/reader_writer_lock_manager_core.sv]
// Reader-writer lock manager with writer preference, for one lock.
// Request channel: i_in_valid / o_in_ready with i_operation and i_task_id.
// Result channel: o_out_valid / i_out_ready with status, task, writer flag,
// reader count and a last flag on the final result of each request.
// A request is classified at the front and held in a two-entry queue; the back
// end executes it against the lock state and the two wait queues.
// Steps: an accepted request is written into the request queue, fetched by the back
// end in its idle state and executed in its exec state, which registers the result.
// The back end fetches and executes one request at a time and takes no new one until
// it has given every result of the last; a write-release that wakes N readers gives N
// results, one per cycle while the receiver is ready, walking the reader wait queue memory.
// The request queue keeps accepting while a result waits at the output, so a
// stalled receiver holds the back end but not the front until the queue fills.
// Reset (synchronous, active low) frees the lock and empties both wait queues
// at once; no clearing pass is needed. Depends on rwl_pkg, rwl_front, rwl_fifo,
// rwl_back.
`timescale 1ns / 1ps

module reader_writer_lock_manager_core
    import rwl_pkg::*;
#(
    parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
    parameter int TASK_ID_BITS = DEF_TASK_ID_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [OP_BITS-1:0]      i_operation,
    input  logic [TASK_ID_BITS-1:0] i_task_id,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [STATUS_BITS-1:0]  o_status,
    output logic [TASK_ID_BITS-1:0] o_task_res,
    output logic                    o_as_writer,
    output logic [RC_BITS-1:0]      o_reader_count,
    output logic                    o_last
);

    localparam int FW = $bits(t_cmd) + TASK_ID_BITS;

    t_cmd                    front_cmd;
    t_cmd                    back_cmd;
    logic                    fifo_full;
    logic                    fifo_valid;
    logic                    fifo_pop;
    logic [FW-1:0]           fifo_rdata;
    logic [TASK_ID_BITS-1:0] back_task;
    t_status                 back_status;

    assign o_in_ready = !fifo_full;
    assign back_cmd   = t_cmd'(fifo_rdata[FW-1:TASK_ID_BITS]);
    assign back_task  = fifo_rdata[TASK_ID_BITS-1:0];
    assign o_status   = back_status;

    rwl_front u_front (
        .i_operation (i_operation),
        .o_cmd       (front_cmd)
    );

    rwl_fifo #(
        .WIDTH (FW),
        .DEPTH (REQ_FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_data  ({front_cmd, i_task_id}),
        .o_full  (fifo_full),
        .i_pop   (fifo_pop),
        .o_valid (fifo_valid),
        .o_data  (fifo_rdata)
    );

    rwl_back #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .TASK_ID_BITS (TASK_ID_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (fifo_valid),
        .i_cmd          (back_cmd),
        .i_cmd_task     (back_task),
        .o_cmd_pop      (fifo_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (back_status),
        .o_task_res     (o_task_res),
        .o_as_writer    (o_as_writer),
        .o_reader_count (o_reader_count),
        .o_last         (o_last)
    );

endmodule

[sim/testbench.sv]
// Self-checking testbench for reader_writer_lock_manager_core: directed and random
// lock requests with random idling on both channels, checked against an in-bench model.
// Depends on rwl_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;
    import rwl_pkg::*;

    localparam int QDEPTH      = DEF_QUEUE_DEPTH;
    localparam int TID_BITS    = DEF_TASK_ID_BITS;
    localparam int REQ_TARGET  = 150;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [OP_BITS-1:0] OP_UNUSED_LO = 3'd6;
    localparam logic [OP_BITS-1:0] OP_UNUSED_HI = 3'd7;

    typedef struct {
        logic [OP_BITS-1:0]  op;
        logic [TID_BITS-1:0] tid;
    } lock_req_t;

    typedef struct {
        t_status             status;
        logic [TID_BITS-1:0] task_res;
        logic                as_writer;
        logic [RC_BITS-1:0]  reader_count;
        logic                last;
    } lock_result_t;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic [OP_BITS-1:0]      i_operation = '0;
    logic [TID_BITS-1:0]     i_task_id = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic [STATUS_BITS-1:0]  o_status;
    logic [TID_BITS-1:0]     o_task_res;
    logic                    o_as_writer;
    logic [RC_BITS-1:0]      o_reader_count;
    logic                    o_last;

    // lock model state
    logic                    wr_held = 1'b0;
    logic [TID_BITS-1:0]     wr_owner = '0;
    int                      rd_holding = 0;
    logic [TID_BITS-1:0]     rd_wait[$];
    logic [TID_BITS-1:0]     wr_wait[$];

    lock_req_t               lock_requests[$];
    lock_result_t            lock_results_due[$];
    lock_result_t            want;
    lock_req_t               next_req;

    int cycle_cnt = 0;
    int sent_cnt = 0;
    int accepted_cnt = 0;
    int result_cnt = 0;
    int fail_cnt = 0;
    int gap_left = 0;
    int stall_left = 0;
    int in_quiet = 0;
    int out_quiet = 0;
    int status_seen[16];

    reader_writer_lock_manager_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_task_id      (i_task_id),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_task_res     (o_task_res),
        .o_as_writer    (o_as_writer),
        .o_reader_count (o_reader_count),
        .o_last         (o_last)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    function automatic int draw_pause(inout int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            quiet_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    function automatic void due_result(t_status st, logic [TID_BITS-1:0] tid, logic wr,
                                       logic fin);
        lock_result_t r;
        r.status       = st;
        r.task_res     = tid;
        r.as_writer    = wr;
        r.reader_count = rd_holding[RC_BITS-1:0];
        r.last         = fin;
        lock_results_due.push_back(r);
    endfunction

    function automatic void lock_apply(logic [OP_BITS-1:0] op, logic [TID_BITS-1:0] tid);
        logic [TID_BITS-1:0] woken;
        case (op)
            OP_RLOCK, OP_TRY_RLOCK: begin
                if (!wr_held && wr_wait.size() == 0) begin
                    if (rd_holding >= COUNT_MAX) begin
                        due_result(ST_COUNTFULL, tid, 1'b0, 1'b1);
                    end else begin
                        rd_holding++;
                        due_result(ST_GRANTED, tid, 1'b0, 1'b1);
                    end
                end else if (op == OP_TRY_RLOCK) begin
                    due_result(ST_REFUSED, tid, 1'b0, 1'b1);
                end else if (rd_wait.size() >= QDEPTH) begin
                    due_result(ST_QFULL, tid, 1'b0, 1'b1);
                end else begin
                    rd_wait.push_back(tid);
                    due_result(ST_QUEUED, tid, 1'b0, 1'b1);
                end
            end
            OP_WLOCK, OP_TRY_WLOCK: begin
                if (!wr_held && rd_holding == 0) begin
                    wr_held  = 1'b1;
                    wr_owner = tid;
                    due_result(ST_GRANTED, tid, 1'b1, 1'b1);
                end else if (op == OP_TRY_WLOCK) begin
                    due_result(ST_REFUSED, tid, 1'b0, 1'b1);
                end else if (wr_wait.size() >= QDEPTH) begin
                    due_result(ST_QFULL, tid, 1'b0, 1'b1);
                end else begin
                    wr_wait.push_back(tid);
                    due_result(ST_QUEUED, tid, 1'b0, 1'b1);
                end
            end
            OP_RUNLOCK: begin
                if (rd_holding == 0) begin
                    due_result(ST_NOREADERS, tid, 1'b0, 1'b1);
                end else begin
                    rd_holding--;
                    if (rd_holding == 0 && wr_wait.size() != 0) begin
                        woken    = wr_wait.pop_front();
                        wr_held  = 1'b1;
                        wr_owner = woken;
                        due_result(ST_WOKE, woken, 1'b1, 1'b1);
                    end else begin
                        due_result(ST_RELEASED, tid, 1'b0, 1'b1);
                    end
                end
            end
            OP_WUNLOCK: begin
                if (!wr_held) begin
                    due_result(ST_NOTLOCKED, tid, 1'b0, 1'b1);
                end else if (rd_holding != 0) begin
                    due_result(ST_READERS, tid, 1'b0, 1'b1);
                end else begin
                    wr_held  = 1'b0;
                    wr_owner = '0;
                    if (rd_wait.size() != 0) begin
                        while (rd_wait.size() != 0) begin
                            woken = rd_wait.pop_front();
                            rd_holding++;
                            due_result(ST_WOKE, woken, 1'b0, rd_wait.size() == 0);
                        end
                    end else if (wr_wait.size() != 0) begin
                        woken    = wr_wait.pop_front();
                        wr_held  = 1'b1;
                        wr_owner = woken;
                        due_result(ST_WOKE, woken, 1'b1, 1'b1);
                    end else begin
                        due_result(ST_RELEASED, tid, 1'b0, 1'b1);
                    end
                end
            end
            default: begin
                due_result(ST_REFUSED, tid, 1'b0, 1'b1);
            end
        endcase
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                lock_apply(i_operation, i_task_id);
                accepted_cnt++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (lock_requests.size() != 0) begin
                    next_req = lock_requests.pop_front();
                    i_operation <= next_req.op;
                    i_task_id   <= next_req.tid;
                    i_in_valid  <= 1'b1;
                    gap_left = draw_pause(in_quiet);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                result_cnt++;
                status_seen[o_status]++;
                if (lock_results_due.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("unexpected result: st=%0d task=%0d wr=%0d rc=%0d last=%0d",
                                 o_status, o_task_res, o_as_writer, o_reader_count, o_last);
                end else begin
                    want = lock_results_due.pop_front();
                    if (o_status !== want.status || o_task_res !== want.task_res ||
                        o_as_writer !== want.as_writer ||
                        o_reader_count !== want.reader_count || o_last !== want.last) begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                            $display("mismatch: exp %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                                     want.status, want.task_res, want.as_writer,
                                     want.reader_count, want.last, o_status, o_task_res,
                                     o_as_writer, o_reader_count, o_last);
                    end
                end
                stall_left = draw_pause(out_quiet);
            end else if (o_out_valid && stall_left > 0) begin
                stall_left--;
            end
            i_out_ready <= (stall_left == 0);
        end
    end

    function automatic void queue_request(logic [OP_BITS-1:0] op, logic [TID_BITS-1:0] tid);
        lock_req_t q;
        q.op  = op;
        q.tid = tid;
        lock_requests.push_back(q);
        sent_cnt++;
    endfunction

    task automatic settle();
        @(negedge i_clk);
        while (lock_requests.size() != 0 || i_in_valid)
            @(negedge i_clk);
    endtask

    function automatic logic [TID_BITS-1:0] any_tid();
        return TID_BITS'($urandom_range(0, 255));
    endfunction

    initial begin
        int pick;
        int n;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        queue_request(OP_TRY_WLOCK, 8'h00);
        queue_request(OP_RLOCK, 8'hFF);
        queue_request(OP_RLOCK, 8'h80);
        queue_request(OP_TRY_RLOCK, 8'h55);
        queue_request(OP_WLOCK, 8'hAA);
        queue_request(OP_TRY_WLOCK, 8'h01);
        queue_request(OP_RUNLOCK, 8'h02);
        queue_request(OP_UNUSED_LO, 8'h33);
        queue_request(OP_UNUSED_HI, 8'hCC);
        queue_request(OP_WUNLOCK, 8'h00);
        queue_request(OP_WUNLOCK, 8'h03);
        queue_request(OP_RLOCK, 8'h04);
        queue_request(OP_TRY_RLOCK, 8'h05);
        queue_request(OP_RUNLOCK, 8'hFF);
        queue_request(OP_RUNLOCK, 8'h80);
        queue_request(OP_WUNLOCK, 8'hAA);
        queue_request(OP_RUNLOCK, 8'h04);
        queue_request(OP_TRY_WLOCK, 8'h07);
        queue_request(OP_WUNLOCK, 8'h07);
        queue_request(OP_WLOCK, 8'h09);
        queue_request(OP_WLOCK, 8'h0A);
        queue_request(OP_WUNLOCK, 8'h09);
        queue_request(OP_WUNLOCK, 8'h0A);
        settle();

        while (sent_cnt < REQ_TARGET) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0: queue_request(OP_BITS'($urandom_range(0, 7)), any_tid());
                1, 2, 3: begin
                    if (wr_held && $urandom_range(0, 2) != 0)
                        queue_request(OP_WUNLOCK, wr_owner);
                    else if (rd_holding > 0 && $urandom_range(0, 1) != 0)
                        queue_request(OP_RUNLOCK, any_tid());
                    else
                        queue_request(OP_BITS'($urandom_range(0, 3)), any_tid());
                end
                4, 5: begin
                    queue_request(OP_TRY_WLOCK, any_tid());
                    n = $urandom_range(1, 20);
                    repeat (n)
                        queue_request(($urandom_range(0, 4) == 0) ? OP_TRY_RLOCK : OP_RLOCK,
                                      any_tid());
                end
                6: begin
                    n = $urandom_range(1, 20);
                    repeat (n)
                        queue_request(($urandom_range(0, 4) == 0) ? OP_TRY_WLOCK : OP_WLOCK,
                                      any_tid());
                end
                7, 8: begin
                    n = $urandom_range(1, 8);
                    repeat (n) begin
                        if (wr_held)
                            queue_request(OP_WUNLOCK, wr_owner);
                        else if (rd_holding > 0)
                            queue_request(OP_RUNLOCK, any_tid());
                        settle();
                    end
                end
                default: begin
                    n = $urandom_range(3, 8);
                    repeat (n)
                        queue_request(OP_BITS'($urandom_range(0, 5)), any_tid());
                end
            endcase
            settle();
        end

        // drain the lock, then fill the reader count to its ceiling
        while (wr_held || rd_holding > 0) begin
            if (wr_held)
                queue_request(OP_WUNLOCK, wr_owner);
            else
                queue_request(OP_RUNLOCK, any_tid());
            settle();
        end
        repeat (COUNT_MAX)
            queue_request(OP_RLOCK, any_tid());
        queue_request(OP_RLOCK, any_tid());
        queue_request(OP_TRY_RLOCK, any_tid());
        queue_request(OP_TRY_WLOCK, any_tid());
        queue_request(OP_WLOCK, any_tid());
        queue_request(OP_RUNLOCK, any_tid());
        queue_request(OP_RLOCK, any_tid());
        queue_request(OP_RUNLOCK, any_tid());
        settle();

        while (lock_results_due.size() != 0)
            @(negedge i_clk);
        repeat (40) @(negedge i_clk);

        $display("summary: %0d requests, %0d results; woke %0d, qfull %0d, countfull %0d",
                 accepted_cnt, result_cnt, status_seen[ST_WOKE], status_seen[ST_QFULL],
                 status_seen[ST_COUNTFULL]);
        $display("summary: %0d mismatches or unexpected results", fail_cnt);
        if (fail_cnt == 0 && lock_results_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

endmodule

[reader_writer_lock_manager_core.f]
hdl/rwl_pkg.sv
hdl/rwl_front.sv
hdl/rwl_fifo.sv
hdl/rwl_back.sv
hdl/reader_writer_lock_manager_core.sv
sim/testbench.sv
